### rtl/lbdr_pkg.sv
// Shared types and constants for the LED breathing duty ramp block.
package lbdr_pkg;

    localparam int DUTY_W       = 16;
    localparam int CHAN_MAX     = 3;
    localparam int LED_COUNT_DEF = 3;
    localparam int STEP_DIV_DEF = 200;

    localparam logic [DUTY_W-1:0] CNT_MAX             = 16'hFFFF;
    localparam logic [DUTY_W-1:0] PWM_PERIOD_RST      = 16'd1024;
    localparam logic [DUTY_W-1:0] START_DELAY_RED_RST = 16'd700;
    localparam logic [DUTY_W-1:0] START_DELAY_GRN_RST = 16'd1400;
    localparam logic [DUTY_W-1:0] START_DELAY_BLU_RST = 16'd2100;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 56;

    typedef enum logic [1:0] {
        REG_PWM_PERIOD  = 2'd0,
        REG_DELAY_RED   = 2'd1,
        REG_DELAY_GREEN = 2'd2,
        REG_DELAY_BLUE  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic              running;
        logic [DUTY_W-1:0] duty;
    } chan_status_t;

endpackage

### rtl/lbdr_channel.sv
// One LED channel: start delay wait, millisecond counter and duty ramp.
module lbdr_channel
    import lbdr_pkg::*;
#(
    parameter int STEP_DIVISOR = STEP_DIV_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  logic [DUTY_W-1:0] pwm_period,
    input  logic [DUTY_W-1:0] start_delay,
    output chan_status_t      status_next
);

    localparam int DIV_W  = $clog2(STEP_DIVISOR + 1);
    localparam int PROD_W = DUTY_W + 1 + DIV_W;

    logic [DUTY_W-1:0] cnt_reg, cnt_next;
    logic [DUTY_W-1:0] duty_reg, duty_next;
    logic              running_reg, running_next;
    logic              rising_reg, rising_next;

    logic [DUTY_W-1:0] cnt_inc;
    logic [DUTY_W:0]   cnt_plus;
    logic [DUTY_W-1:0] diff;
    logic [PROD_W-1:0] limit;
    logic              step;
    logic [DUTY_W-1:0] duty_up, duty_dn;

    always_comb begin
        cnt_inc  = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + 1'b1;
        cnt_plus = {1'b0, cnt_inc} + 1'b1;
        diff     = (pwm_period > duty_reg) ? pwm_period - duty_reg : '0;
        limit    = PROD_W'(cnt_plus) * PROD_W'(STEP_DIVISOR);
        // counter >= diff / divisor  <=>  diff < (counter + 1) * divisor
        step     = PROD_W'(diff) < limit;
        duty_up  = duty_reg + 1'b1;
        duty_dn  = duty_reg - 1'b1;
    end

    always_comb begin
        cnt_next     = cnt_reg;
        duty_next    = duty_reg;
        running_next = running_reg;
        rising_next  = rising_reg;
        if (advance) begin
            if (!running_reg) begin
                if (cnt_inc > start_delay) begin
                    running_next = 1'b1;
                    rising_next  = 1'b1;
                    duty_next    = '0;
                    cnt_next     = '0;
                end else begin
                    cnt_next = cnt_inc;
                end
            end else if (!step) begin
                cnt_next = cnt_inc;
            end else begin
                cnt_next = '0;
                if (rising_reg) begin
                    if (duty_reg >= pwm_period) begin
                        duty_next   = pwm_period;
                        rising_next = 1'b0;
                    end else begin
                        duty_next = duty_up;
                        if (duty_up == pwm_period) begin
                            rising_next = 1'b0;
                        end
                    end
                end else begin
                    if (duty_reg == '0) begin
                        rising_next = 1'b1;
                    end else begin
                        duty_next = duty_dn;
                        if (duty_dn == '0) begin
                            rising_next = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            duty_reg    <= '0;
            running_reg <= 1'b0;
            rising_reg  <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            duty_reg    <= duty_next;
            running_reg <= running_next;
            rising_reg  <= rising_next;
        end
    end

    assign status_next.running = running_next;
    assign status_next.duty    = running_next ? duty_next : '0;

endmodule

### rtl/led_breathing_duty_ramp_top.sv
// Top level of the LED breathing duty ramp: config registers, channels, output skid.
//
// Usage:
//   Send one word per millisecond on the s_ channel; s_tdata[0] = 1 advances
//   time by one millisecond, 0 only reports the current duty values.
//   Each accepted word yields exactly one result word on the m_ channel with
//   the three PWM compare values and the mask of running channels, taken
//   after the update that the word causes.
//   Output: each result word is registered before it is shown on the m_ channel.
//   Throughput: one word per cycle while s_tready is high; the channel update is a
//   single pass of increment, one constant multiply and compare, and a +/-1 step.
//   Configuration: cfg_we writes cfg_wdata to register cfg_addr (0 period,
//   1..3 start delays red, green, blue); write only while the block is idle.
//   Reset: all channels stop and wait for their start delay, counters and
//   duty values clear, registers return to their defaults.
//   Stall: a two-word output stage (result register plus skid) keeps taking
//   input while one result waits; s_tready drops when both are occupied.
module led_breathing_duty_ramp_top
    import lbdr_pkg::*;
#(
    parameter int LED_COUNT    = LED_COUNT_DEF,
    parameter int STEP_DIVISOR = STEP_DIV_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [0] tick, [7:1] zero
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [15:0] duty_red, [31:16] duty_green,
                                            // [47:32] duty_blue, [50:48] active_mask
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_addr,
    input  logic [DUTY_W-1:0]    cfg_wdata
);

    logic [DUTY_W-1:0] period_reg;
    logic [DUTY_W-1:0] delay_reg [CHAN_MAX];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg  <= PWM_PERIOD_RST;
            delay_reg[0] <= START_DELAY_RED_RST;
            delay_reg[1] <= START_DELAY_GRN_RST;
            delay_reg[2] <= START_DELAY_BLU_RST;
        end else if (cfg_we) begin
            unique case (reg_idx_t'(cfg_addr))
                REG_PWM_PERIOD:  period_reg   <= cfg_wdata;
                REG_DELAY_RED:   delay_reg[0] <= cfg_wdata;
                REG_DELAY_GREEN: delay_reg[1] <= cfg_wdata;
                REG_DELAY_BLUE:  delay_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic         in_accept;
    logic         advance;
    chan_status_t status [CHAN_MAX];
    logic [M_TDATA_W-1:0] result;

    assign in_accept = s_tvalid && s_tready;
    assign advance   = in_accept && s_tdata[0];

    for (genvar c = 0; c < CHAN_MAX; c++) begin : g_chan
        if (c < LED_COUNT) begin : g_used
            lbdr_channel #(
                .STEP_DIVISOR(STEP_DIVISOR)
            ) u_channel (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .advance    (advance),
                .pwm_period (period_reg),
                .start_delay(delay_reg[c]),
                .status_next(status[c])
            );
        end else begin : g_idle
            assign status[c] = '0;
        end
    end

    assign result = {5'b0,
                     status[2].running, status[1].running, status[0].running,
                     status[2].duty, status[1].duty, status[0].duty};

    logic                 out_valid_reg, skid_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg, skid_data_reg;

    assign s_tready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= in_accept;
            end
        end else if (in_accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : result;
        end else if (in_accept) begin
            skid_data_reg <= result;
        end
    end

endmodule

### rtl/lbdr_checker.sv
// Port-level assertions for the LED breathing duty ramp top level, with bind.
module lbdr_checker
    import lbdr_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_full_has_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input blocked with no result pending");

    a_red_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[48] |-> m_tdata[15:0] == 16'd0)
        else $error("red duty nonzero while red is idle");

    a_blue_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[50] |-> m_tdata[47:32] == 16'd0)
        else $error("blue duty nonzero while blue is idle");

endmodule

bind led_breathing_duty_ramp_top lbdr_checker u_lbdr_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench: predicts the three duty values and the mask for every word.
module testbench;
    import lbdr_pkg::*;

    typedef struct packed {
        logic [4:0]        pad;
        logic [2:0]        mask;
        logic [DUTY_W-1:0] blue;
        logic [DUTY_W-1:0] green;
        logic [DUTY_W-1:0] red;
    } duty_word_t;

    class duty_scoreboard;
        logic [DUTY_W-1:0] period;
        logic [DUTY_W-1:0] delay [CHAN_MAX];
        logic [DUTY_W-1:0] ms_cnt [CHAN_MAX];
        logic [DUTY_W-1:0] duty [CHAN_MAX];
        bit                running [CHAN_MAX];
        bit                rising [CHAN_MAX];
        duty_word_t        duty_q [$];
        int                errors;

        function new();
            period   = PWM_PERIOD_RST;
            delay[0] = START_DELAY_RED_RST;
            delay[1] = START_DELAY_GRN_RST;
            delay[2] = START_DELAY_BLU_RST;
            for (int c = 0; c < CHAN_MAX; c++) begin
                ms_cnt[c]  = '0;
                duty[c]    = '0;
                running[c] = 1'b0;
                rising[c]  = 1'b0;
            end
            errors = 0;
        endfunction

        function void write_reg(reg_idx_t idx, logic [DUTY_W-1:0] v);
            case (idx)
                REG_PWM_PERIOD:  period   = v;
                REG_DELAY_RED:   delay[0] = v;
                REG_DELAY_GREEN: delay[1] = v;
                REG_DELAY_BLUE:  delay[2] = v;
            endcase
        endfunction

        function void advance(int c);
            int thr;
            if (ms_cnt[c] != CNT_MAX) ms_cnt[c]++;
            if (!running[c]) begin
                if (ms_cnt[c] > delay[c]) begin
                    running[c] = 1'b1;
                    rising[c]  = 1'b1;
                    duty[c]    = '0;
                    ms_cnt[c]  = '0;
                end
                return;
            end
            thr = (period > duty[c]) ? (int'(period) - int'(duty[c])) / STEP_DIV_DEF : 0;
            if (int'(ms_cnt[c]) < thr) return;
            ms_cnt[c] = '0;
            if (rising[c]) begin
                if (duty[c] >= period) begin
                    duty[c]   = period;
                    rising[c] = 1'b0;
                end else begin
                    duty[c]++;
                    if (duty[c] == period) rising[c] = 1'b0;
                end
            end else if (duty[c] == '0) begin
                rising[c] = 1'b1;
            end else begin
                duty[c]--;
                if (duty[c] == '0) rising[c] = 1'b1;
            end
        endfunction

        function void note_tick(logic tick);
            duty_word_t        w;
            logic [DUTY_W-1:0] lvl [CHAN_MAX];
            w = '0;
            for (int c = 0; c < CHAN_MAX; c++) begin
                if (tick) advance(c);
                lvl[c]    = running[c] ? duty[c] : '0;
                w.mask[c] = running[c];
            end
            w.red   = lvl[0];
            w.green = lvl[1];
            w.blue  = lvl[2];
            duty_q.push_back(w);
        endfunction

        function void field_check(string name, int exp_v, int got_v);
            if (exp_v != got_v) begin
                errors++;
                if (errors <= 10) $display("%s: expected %0d, got %0d", name, exp_v, got_v);
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data);
            duty_word_t got;
            duty_word_t want;
            got = data;
            if (duty_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word %h", data);
                return;
            end
            want = duty_q.pop_front();
            field_check("duty_red", int'(want.red), int'(got.red));
            field_check("duty_green", int'(want.green), int'(got.green));
            field_check("duty_blue", int'(want.blue), int'(got.blue));
            field_check("active_mask", int'(want.mask), int'(got.mask));
        endfunction

        function int pending();
            return duty_q.size();
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_we;
    logic [1:0]           cfg_addr;
    logic [DUTY_W-1:0]    cfg_wdata;

    duty_scoreboard sb;
    int             src_idle = 0;
    int             snk_idle = 0;
    int             hold_left = 0;

    led_breathing_duty_ramp_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_tick(s_tdata[0]);
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
        end
    end

    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready = 1'b0;
            hold_left--;
        end else begin
            m_tready = ($urandom_range(99) >= snk_idle);
        end
    end

    task automatic send_tick(input logic tick);
        s_tvalid = 1'b0;
        while ($urandom_range(99) < src_idle) @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {{(S_TDATA_W-1){1'b0}}, tick};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic drain();
        while (sb.pending() != 0) @(negedge aclk);
    endtask

    task automatic cfg_write(input reg_idx_t idx, input logic [DUTY_W-1:0] v);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = v;
        @(negedge aclk);
        cfg_we = 1'b0;
        sb.write_reg(idx, v);
    endtask

    task automatic set_config(input logic [DUTY_W-1:0] per, input logic [DUTY_W-1:0] d_red,
                              input logic [DUTY_W-1:0] d_green,
                              input logic [DUTY_W-1:0] d_blue);
        drain();
        cfg_write(REG_PWM_PERIOD, per);
        cfg_write(REG_DELAY_RED, d_red);
        cfg_write(REG_DELAY_GREEN, d_green);
        cfg_write(REG_DELAY_BLUE, d_blue);
    endtask

    initial begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int                sent;
        int                len;
        int                mode;
        bit                hold_done;
        logic [DUTY_W-1:0] per;
        sb        = new();
        sent      = 0;
        hold_done = 1'b0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_addr  = REG_PWM_PERIOD;
        cfg_wdata = '0;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;

        // defaults: every channel still waits
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);

        // period of one, zero red delay, blue parked on the never-start delay
        set_config(16'd1, 16'd0, 16'd2, CNT_MAX);
        repeat (6) send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);

        set_config(16'd0, 16'd0, 16'd2, CNT_MAX);
        repeat (4) send_tick(1'b1);
        send_tick(1'b0);

        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, CNT_MAX);
        repeat (4) send_tick(1'b1);

        // hold blue back, then change the delays under running channels
        set_config(16'd40, 16'h5A5A, 16'hA5A5, CNT_MAX);
        repeat (40) send_tick(1'b1);
        set_config(16'd7, 16'h0001, 16'hFFFE, 16'hFFFE);
        send_tick(1'b1);
        send_tick(1'b0);

        while (sent < 1750) begin
            mode = sent * 3 / 1750;
            case (mode)
                0: begin
                    src_idle = 25;
                    snk_idle = 61;
                end
                1: begin
                    src_idle = 61;
                    snk_idle = 25;
                end
                default: begin
                    src_idle = 0;
                    snk_idle = 0;
                end
            endcase
            case ($urandom_range(9))
                0: per = 16'd0;
                1: per = 16'hFFFF;
                2: per = 16'd1;
                3: per = DUTY_W'($urandom_range(16'hFFFF));
                default: per = DUTY_W'($urandom_range(80, 2));
            endcase
            len = $urandom_range(200, 60);
            set_config(per, DUTY_W'($urandom_range(400)), DUTY_W'($urandom_range(400)),
                       DUTY_W'($urandom_range(400)));
            if (mode == 2 && !hold_done) begin
                hold_left = 400;
                hold_done = 1'b1;
            end
            repeat (len) send_tick($urandom_range(99) < 80);
            sent += len;
        end

        drain();
        repeat (10) @(negedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
